// ----- rtl/tgep_pkg.sv -----
// ----------------------------------------------------------------------------
// Threshold gate edge pulser package
// Shared widths, reset values and register indexes of the edge pulser.
// ----------------------------------------------------------------------------
`default_nettype none

package tgep_pkg;

   // default widths of the sample path and of the pulse countdowns
   localparam int SAMPLE_BITS_DEF = 16;
   localparam int COUNT_BITS_DEF  = 16;

   // register reset values, cut to the configured widths where they are used
   localparam int THRESHOLD_RESET     = 16384;
   localparam int PULSE_SAMPLES_RESET = 0;
   localparam int TRIGGER_LEVEL_RESET = 32767;
   localparam int PULSE_LEVEL_RESET   = 32767;

   // register index carried on the csr write channel
   localparam int CSR_INDEX_BITS = 2;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_THRESHOLD     = 2'd0,
      CSR_PULSE_SAMPLES = 2'd1,
      CSR_TRIGGER_LEVEL = 2'd2,
      CSR_PULSE_LEVEL   = 2'd3
   } csr_index_type;

endpackage : tgep_pkg

`default_nettype wire

// ----- rtl/threshold_gate_edge_pulser.sv -----
// ----------------------------------------------------------------------------
// Threshold gate edge pulser
// Compares each signed sample with a threshold and gives gate, hold and
// edge pulse outputs with stretched plateaus after each edge.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one signed sample per transfer. rsp_* carries one result per
//   sample: gate, inverted gate, hold, up, down and their sum, packed in
//   rsp_tdata. csr_* writes the four registers (threshold, pulse length,
//   trigger level, pulse level); it is always ready and should only be used
//   while no result is outstanding.
//   The result is registered and appears in the cycle after its sample transfer.
//   Throughput: one sample per cycle while results are taken. The compare, the equality check and the
//   two countdown updates sit between the sample input and the result
//   register, so the result register is the only pipeline stage.
//   Stall: while rsp_tvalid is high and rsp_tready low the result holds and
//   req_tready drops; when the result is taken a new sample may be accepted
//   in the same cycle.
//   Reset: registers return to threshold 2^14, pulse length 0, levels 32767;
//   edge state, previous sample and countdowns clear, and the result register
//   empties. The first sample after reset has no hold and counts as a rising
//   edge if it is above the threshold.
// ----------------------------------------------------------------------------
`default_nettype none

module threshold_gate_edge_pulser #(
   parameter int SAMPLE_BITS = tgep_pkg::SAMPLE_BITS_DEF,
   parameter int COUNT_BITS  = tgep_pkg::COUNT_BITS_DEF,
   localparam int CSR_DATA_BITS = (SAMPLE_BITS > COUNT_BITS) ? SAMPLE_BITS : COUNT_BITS,
   localparam int RSP_BITS      = 6 * SAMPLE_BITS + 4,
   localparam int RSP_DATA_BITS = ((RSP_BITS + 7) / 8) * 8,
   localparam int REQ_DATA_BITS = ((SAMPLE_BITS + 7) / 8) * 8
) (
   input  wire                              clock,
   input  wire                              reset,
   // sample stream
   input  wire                              req_tvalid,
   output logic                             req_tready,
   input  wire  [REQ_DATA_BITS-1:0]         req_tdata,   // sample
   // result stream
   output logic                             rsp_tvalid,
   input  wire                              rsp_tready,
   // gate_out, inv_gate_out, hold_out, up_out, down_out, both_edges_out, pad
   output logic [RSP_DATA_BITS-1:0]         rsp_tdata,
   // register writes
   input  wire                              csr_valid,
   output logic                             csr_ready,
   input  tgep_pkg::csr_index_type          csr_index,
   input  wire  [CSR_DATA_BITS-1:0]         csr_data
);

   import tgep_pkg::*;

   // configuration registers
   logic signed [SAMPLE_BITS-1:0] threshold_ff;
   logic        [COUNT_BITS-1:0]  pulse_samples_ff;
   logic signed [SAMPLE_BITS-1:0] trigger_level_ff;
   logic signed [SAMPLE_BITS-1:0] pulse_level_ff;

   // edge and hold state
   logic                          was_high_ff, was_high_in;
   logic                          have_previous_ff;
   logic signed [SAMPLE_BITS-1:0] previous_sample_ff;
   logic        [COUNT_BITS-1:0]  up_remaining_ff, up_remaining_in;
   logic        [COUNT_BITS-1:0]  down_remaining_ff, down_remaining_in;

   // result register
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_BITS-1:0]      rsp_data_ff, rsp_data_in;

   logic                          req_accept;
   logic                          rsp_accept;
   logic                          csr_accept;

   logic signed [SAMPLE_BITS-1:0] sample;
   logic                          high;
   logic                          rising;
   logic                          falling;
   logic                          same;
   logic        [COUNT_BITS-1:0]  up_count;
   logic        [COUNT_BITS-1:0]  down_count;
   logic signed [SAMPLE_BITS-1:0] gate_val;
   logic signed [SAMPLE_BITS-1:0] inv_gate_val;
   logic signed [SAMPLE_BITS-1:0] hold_val;
   logic signed [SAMPLE_BITS:0]   up_val;
   logic signed [SAMPLE_BITS:0]   down_val;
   logic signed [SAMPLE_BITS+1:0] both_val;

   // handshakes
   assign rsp_accept = rsp_valid_ff & rsp_tready;
   assign req_tready = ~rsp_valid_ff | rsp_tready;
   assign req_accept = req_tvalid & req_tready;
   assign csr_ready  = 1'b1;
   assign csr_accept = csr_valid & csr_ready;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff     <= SAMPLE_BITS'(THRESHOLD_RESET);
         pulse_samples_ff <= COUNT_BITS'(PULSE_SAMPLES_RESET);
         trigger_level_ff <= SAMPLE_BITS'(TRIGGER_LEVEL_RESET);
         pulse_level_ff   <= SAMPLE_BITS'(PULSE_LEVEL_RESET);
      end else if (csr_accept) begin
         unique case (csr_index)
            CSR_THRESHOLD:     threshold_ff     <= csr_data[SAMPLE_BITS-1:0];
            CSR_PULSE_SAMPLES: pulse_samples_ff <= csr_data[COUNT_BITS-1:0];
            CSR_TRIGGER_LEVEL: trigger_level_ff <= csr_data[SAMPLE_BITS-1:0];
            CSR_PULSE_LEVEL:   pulse_level_ff   <= csr_data[SAMPLE_BITS-1:0];
            default: ;
         endcase
      end
   end

   // compare and edge detection
   assign sample  = req_tdata[SAMPLE_BITS-1:0];
   assign high    = sample > threshold_ff;
   assign rising  = high & ~was_high_ff;
   assign falling = ~high & was_high_ff;
   assign same    = have_previous_ff & (sample == previous_sample_ff);
   assign was_high_in = high;

   // countdowns: reload on an edge, then plateau and decrement while nonzero
   always_comb begin
      up_count   = rising  ? pulse_samples_ff : up_remaining_ff;
      down_count = falling ? pulse_samples_ff : down_remaining_ff;
      up_remaining_in   = (up_count != '0)   ? up_count - 1'b1   : up_count;
      down_remaining_in = (down_count != '0) ? down_count - 1'b1 : down_count;
   end

   // output levels
   always_comb begin
      gate_val     = high  ? trigger_level_ff : '0;
      inv_gate_val = high  ? '0 : trigger_level_ff;
      hold_val     = same  ? trigger_level_ff : '0;
      up_val       = (rising ? (SAMPLE_BITS+1)'(trigger_level_ff) : '0)
                   + ((up_count != '0) ? (SAMPLE_BITS+1)'(pulse_level_ff) : '0);
      down_val     = (falling ? (SAMPLE_BITS+1)'(trigger_level_ff) : '0)
                   + ((down_count != '0) ? (SAMPLE_BITS+1)'(pulse_level_ff) : '0);
      both_val     = (SAMPLE_BITS+2)'(up_val) + (SAMPLE_BITS+2)'(down_val);
   end

   // result packing, zero padded to whole bytes, and result register control
   always_comb begin
      rsp_data_in = RSP_DATA_BITS'({both_val, down_val, up_val,
                                    hold_val, inv_gate_val, gate_val});
      if (req_accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_accept) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // state and result registers
   always_ff @(posedge clock) begin
      if (reset) begin
         was_high_ff       <= 1'b0;
         have_previous_ff  <= 1'b0;
         previous_sample_ff <= '0;
         up_remaining_ff   <= '0;
         down_remaining_ff <= '0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_accept) begin
            was_high_ff        <= was_high_in;
            have_previous_ff   <= 1'b1;
            previous_sample_ff <= sample;
            up_remaining_ff    <= up_remaining_in;
            down_remaining_ff  <= down_remaining_in;
         end
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef NO_ASSERTIONS
   // a held result blocks new samples
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |-> !req_accept)
      else $error("sample taken while result stalled");

   // every accepted sample leaves a result waiting
   assert property (@(posedge clock) disable iff (reset)
      req_accept |=> rsp_valid_ff)
      else $error("result missing after sample transfer");

   // gate and inverted gate are never both set
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff[SAMPLE_BITS-1:0] == '0 ||
                        rsp_data_ff[2*SAMPLE_BITS-1:SAMPLE_BITS] == '0))
      else $error("gate and inverted gate both active");
`endif

endmodule : threshold_gate_edge_pulser

`default_nettype wire

// ----- verif/threshold_gate_edge_pulser_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Threshold gate edge pulser testbench
// Streams signed samples through the pulser under several register settings
// and idle patterns, and compares every result transfer field by field with
// typed values or a cycle-free model of the gate, hold and edge pulse logic.
// ----------------------------------------------------------------------------

module threshold_gate_edge_pulser_tb;

   import tgep_pkg::*;

   // one result, unpacked from rsp_tdata
   typedef struct packed {
      logic signed [15:0] gate;
      logic signed [15:0] inv_gate;
      logic signed [15:0] hold;
      logic signed [16:0] up;
      logic signed [16:0] down;
      logic signed [17:0] both_edges;
   } pulser_outputs_type;

   typedef enum logic [1:0] {
      ROW_WRITE,
      ROW_SAMPLE,
      ROW_SAMPLE_KNOWN
   } script_kind_type;

   typedef struct packed {
      script_kind_type    kind;
      csr_index_type      index;
      logic [15:0]        value;
      pulser_outputs_type known;
   } script_row_type;

   localparam int DIRECTED_ROWS = 26;
   localparam int SEGMENTS      = 8;
   localparam int SEGMENT_ITEMS = 125;

   logic          clock;
   logic          reset       = 1'b1;
   logic          req_tvalid  = 1'b0;
   logic          req_tready;
   logic [15:0]   req_tdata   = '0;
   logic          rsp_tvalid;
   logic          rsp_tready  = 1'b0;
   logic [103:0]  rsp_tdata;
   logic          csr_valid   = 1'b0;
   logic          csr_ready;
   csr_index_type csr_index   = CSR_THRESHOLD;
   logic [15:0]   csr_data    = '0;

   // register copies and edge state of the model
   logic signed [15:0] cfg_threshold       = 16'sh4000;
   logic        [15:0] cfg_pulse_samples   = 16'h0000;
   logic signed [15:0] cfg_trigger_level   = 16'sh7FFF;
   logic signed [15:0] cfg_pulse_level     = 16'sh7FFF;
   logic               model_was_high      = 1'b0;
   logic               model_have_previous = 1'b0;
   logic signed [15:0] model_previous      = '0;
   logic        [15:0] model_up_remaining  = '0;
   logic        [15:0] model_down_remaining = '0;

   pulser_outputs_type pending_outputs [$];
   pulser_outputs_type want_outputs;
   int                 error_count    = 0;
   int                 send_idle_pct  = 0;
   int                 recv_stall_pct = 0;

   // directed part: typed results only where they are obvious
   script_row_type directed_script [DIRECTED_ROWS] = '{
      // reset settings, first sample has no hold
      '{ROW_SAMPLE_KNOWN, CSR_THRESHOLD, 16'h0000, '{0, 32767, 0, 0, 0, 0}},
      '{ROW_SAMPLE_KNOWN, CSR_THRESHOLD, 16'h0000, '{0, 32767, 32767, 0, 0, 0}},
      // equal to threshold is not high
      '{ROW_SAMPLE_KNOWN, CSR_THRESHOLD, 16'h4000, '{0, 32767, 0, 0, 0, 0}},
      // rising edge with zero pulse length gives the spike only
      '{ROW_SAMPLE_KNOWN, CSR_THRESHOLD, 16'h4001, '{32767, 0, 0, 32767, 0, 32767}},
      '{ROW_SAMPLE_KNOWN, CSR_THRESHOLD, 16'h7FFF, '{32767, 0, 0, 0, 0, 0}},
      '{ROW_SAMPLE_KNOWN, CSR_THRESHOLD, 16'h8000, '{0, 32767, 0, 0, 32767, 32767}},
      // negative extremes, short plateau
      '{ROW_WRITE,  CSR_PULSE_SAMPLES, 16'h0003, '0},
      '{ROW_WRITE,  CSR_THRESHOLD,     16'h8000, '0},
      '{ROW_WRITE,  CSR_TRIGGER_LEVEL, 16'h8000, '0},
      '{ROW_WRITE,  CSR_PULSE_LEVEL,   16'h8000, '0},
      '{ROW_SAMPLE, CSR_THRESHOLD,     16'h8000, '0},
      '{ROW_SAMPLE, CSR_THRESHOLD,     16'h8001, '0},
      '{ROW_SAMPLE, CSR_THRESHOLD,     16'h8000, '0},
      '{ROW_SAMPLE, CSR_THRESHOLD,     16'h0000, '0},
      '{ROW_SAMPLE, CSR_THRESHOLD,     16'h0000, '0},
      '{ROW_SAMPLE, CSR_THRESHOLD,     16'h0000, '0},
      // positive extremes, longest plateau, nothing can be high
      '{ROW_WRITE,  CSR_THRESHOLD,     16'h7FFF, '0},
      '{ROW_WRITE,  CSR_PULSE_SAMPLES, 16'hFFFF, '0},
      '{ROW_WRITE,  CSR_TRIGGER_LEVEL, 16'h7FFF, '0},
      '{ROW_WRITE,  CSR_PULSE_LEVEL,   16'h7FFF, '0},
      '{ROW_SAMPLE, CSR_THRESHOLD,     16'h7FFF, '0},
      '{ROW_SAMPLE, CSR_THRESHOLD,     16'h0000, '0},
      // one-sample plateau, largest spike plus plateau
      '{ROW_WRITE,  CSR_PULSE_SAMPLES, 16'h0001, '0},
      '{ROW_WRITE,  CSR_THRESHOLD,     16'h0000, '0},
      '{ROW_SAMPLE, CSR_THRESHOLD,     16'h0001, '0},
      '{ROW_SAMPLE, CSR_THRESHOLD,     16'h0000, '0}
   };

   threshold_gate_edge_pulser uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // gate, hold and edge pulse outputs for one sample; advances the edge state
   function automatic pulser_outputs_type next_pulser_outputs(logic signed [15:0] sample);
      pulser_outputs_type result;
      logic               is_high;
      logic               rising;
      logic               falling;
      logic               same;
      logic signed [16:0] up_level;
      logic signed [16:0] down_level;
      is_high    = sample > cfg_threshold;
      rising     = is_high && !model_was_high;
      falling    = !is_high && model_was_high;
      same       = model_have_previous && (sample == model_previous);
      up_level   = '0;
      down_level = '0;
      model_was_high      = is_high;
      model_previous      = sample;
      model_have_previous = 1'b1;
      // an edge gives the spike and restarts its countdown
      if (rising) begin
         up_level           = cfg_trigger_level;
         model_up_remaining = cfg_pulse_samples;
      end
      if (falling) begin
         down_level           = cfg_trigger_level;
         model_down_remaining = cfg_pulse_samples;
      end
      // plateau while the countdown runs
      if (model_up_remaining != 0) begin
         up_level           = up_level + cfg_pulse_level;
         model_up_remaining = model_up_remaining - 1'b1;
      end
      if (model_down_remaining != 0) begin
         down_level           = down_level + cfg_pulse_level;
         model_down_remaining = model_down_remaining - 1'b1;
      end
      result.gate       = is_high ? cfg_trigger_level : 16'sd0;
      result.inv_gate   = is_high ? 16'sd0 : cfg_trigger_level;
      result.hold       = same ? cfg_trigger_level : 16'sd0;
      result.up         = up_level;
      result.down       = down_level;
      result.both_edges = up_level + down_level;
      return result;
   endfunction

   task automatic report_mismatch(string what);
      $display("mismatch at %0t: %s", $realtime, what);
      error_count++;
   endtask

   task automatic compare_field(string name, int got, int want);
      if (got != want)
         report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
   endtask

   // one sample transfer; the expectation is typed in or predicted
   task automatic send_sample(logic [15:0] value, bit use_typed,
                              pulser_outputs_type typed_outputs);
      pulser_outputs_type predicted;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      do @(posedge clock); while (!req_tready);
      predicted = next_pulser_outputs(value);
      pending_outputs.push_back(use_typed ? typed_outputs : predicted);
      @(negedge clock);
   endtask

   // register write once every result is back and the result stage is empty
   task automatic write_register(csr_index_type index, logic [15:0] value);
      req_tvalid <= 1'b0;
      while (pending_outputs.size() != 0) @(negedge clock);
      repeat (2) @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      case (index)
         CSR_THRESHOLD:     cfg_threshold     = value;
         CSR_PULSE_SAMPLES: cfg_pulse_samples = value;
         CSR_TRIGGER_LEVEL: cfg_trigger_level = value;
         CSR_PULSE_LEVEL:   cfg_pulse_level   = value;
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // receiver stalls
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // result transfers against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_outputs.size() == 0) begin
            report_mismatch("result transfer with no sample outstanding");
         end else begin
            want_outputs = pending_outputs.pop_front();
            compare_field("gate_out", int'(signed'(rsp_tdata[15:0])),
                          int'(want_outputs.gate));
            compare_field("inv_gate_out", int'(signed'(rsp_tdata[31:16])),
                          int'(want_outputs.inv_gate));
            compare_field("hold_out", int'(signed'(rsp_tdata[47:32])),
                          int'(want_outputs.hold));
            compare_field("up_out", int'(signed'(rsp_tdata[64:48])),
                          int'(want_outputs.up));
            compare_field("down_out", int'(signed'(rsp_tdata[81:65])),
                          int'(want_outputs.down));
            compare_field("both_edges_out", int'(signed'(rsp_tdata[99:82])),
                          int'(want_outputs.both_edges));
         end
      end
   end

   initial begin
      int          pick;
      int          near_value;
      logic [15:0] reg_value;
      logic [15:0] sample_value;
      logic [15:0] last_sample;

      last_sample = '0;
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed rows, no idling
      foreach (directed_script[i]) begin
         case (directed_script[i].kind)
            ROW_WRITE:        write_register(directed_script[i].index, directed_script[i].value);
            ROW_SAMPLE:       send_sample(directed_script[i].value, 1'b0, '0);
            ROW_SAMPLE_KNOWN: send_sample(directed_script[i].value, 1'b1,
                                          directed_script[i].known);
            default: ;
         endcase
      end

      // random segments, each with fresh settings and its own idle pattern
      for (int seg = 0; seg < SEGMENTS; seg++) begin
         case (seg % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 71; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 71; end
            default: begin send_idle_pct = 6; recv_stall_pct = 6; end
         endcase
         for (int r = 0; r < 4; r++) begin
            pick = $urandom_range(7);
            if (csr_index_type'(r) == CSR_PULSE_SAMPLES) begin
               case (pick)
                  0:       reg_value = 16'h0000;
                  1:       reg_value = 16'hFFFF;
                  2, 3:    reg_value = 16'($urandom_range(40, 1));
                  default: reg_value = 16'($urandom_range(8, 1));
               endcase
            end else begin
               case (pick)
                  0:       reg_value = 16'h8000;
                  1:       reg_value = 16'h7FFF;
                  2, 3, 4: reg_value = 16'($urandom);
                  default: reg_value = 16'(int'($urandom_range(400)) - 200);
               endcase
            end
            write_register(csr_index_type'(r), reg_value);
         end
         for (int n = 0; n < SEGMENT_ITEMS; n++) begin
            pick = $urandom_range(9);
            if (pick < 4) begin
               // close to the threshold so edges come often
               near_value = int'(cfg_threshold) + int'($urandom_range(8)) - 4;
               if (near_value > 32767) near_value = 32767;
               if (near_value < -32768) near_value = -32768;
               sample_value = 16'(near_value);
            end else if (pick < 6) begin
               sample_value = last_sample;
            end else begin
               sample_value = 16'($urandom);
            end
            send_sample(sample_value, 1'b0, '0);
            last_sample = sample_value;
         end
      end

      // drain
      req_tvalid <= 1'b0;
      while (pending_outputs.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
      if (error_count == 0)
         $display("threshold_gate_edge_pulser_tb OK");
      else
         $display("threshold_gate_edge_pulser_tb NOT OK");
      $finish;
   end

   // watchdog
   initial begin
      #2_000_000;
      $display("threshold_gate_edge_pulser_tb NOT OK");
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/tgep_pkg.sv
rtl/threshold_gate_edge_pulser.sv
verif/threshold_gate_edge_pulser_tb.sv
